>>> rtl/ckd_pkg.sv
// ckd_pkg: types and constants for chunk_keystream_decrypt.
// MD5 round tables and the Murmur constants. No dependencies.
package ckd_pkg;

	localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
	localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
	localparam logic [63:0] FMIX_M1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FMIX_M2 = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] DESC_LEN = 64'h10;
	localparam logic [31:0] MD5_A0 = 32'h67452301;
	localparam logic [31:0] MD5_B0 = 32'hefcdab89;
	localparam logic [31:0] MD5_C0 = 32'h98badcfe;
	localparam logic [31:0] MD5_D0 = 32'h10325476;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_DATA  = 1'b1;

	typedef enum logic [2:0] {
		REG_SEED = 3'd0,
		REG_KEY0 = 3'd1,
		REG_KEY1 = 3'd2,
		REG_KEY2 = 3'd3,
		REG_KEY3 = 3'd4
	} reg_idx_t;

	// Top sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_MD5,
		ST_OUT
	} ckd_state_t;

	// Murmur sequencer steps (one 64x64 low multiply per step, except MM_FIN and MM_DONE)
	typedef enum logic [4:0] {
		MM_K1A, MM_K1B, MM_H1A, MM_H1B,
		MM_K2A, MM_K2B, MM_H2A, MM_H2B,
		MM_FIN,
		MM_F1A, MM_F1B, MM_F2A, MM_F2B,
		MM_DONE
	} mm_step_t;

	typedef struct packed {
		logic start;
		logic done;
	} ckd_ctl_t;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] t [64];
		t = '{
			32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
			32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
			32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
			32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
			32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
			32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
			32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
			32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
			32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
			32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
			32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
			32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
			32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
			32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
			32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
			32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
		};
		return t[i];
	endfunction

	function automatic logic [4:0] md5_s(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(5 * i[3:0] + 1);
			2'd2: g = 4'(3 * i[3:0] + 5);
			default: g = 4'(7 * i[3:0]);
		endcase
		return g;
	endfunction

endpackage

>>> rtl/ckd_stream_if.sv
// ckd_stream_if: valid/ready channel carrying input or result payload.
// Depends on nothing.
interface ckd_stream_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [63:0] desc_low;
	logic [63:0] desc_high;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last_in;
	logic [63:0] plain_word;
	logic [3:0]  plain_count;
	logic        last_out;

	modport source (output valid, func, desc_low, desc_high, data_word, byte_count,
		last_in, plain_word, plain_count, last_out, input ready);
	modport sink (input valid, func, desc_low, desc_high, data_word, byte_count,
		last_in, plain_word, plain_count, last_out, output ready);
endinterface

>>> rtl/ckd_murmur.sv
// ckd_murmur: MurmurHash3 x64 128 of a 16-byte block, one shared 32x32
// multiplier; each 64-bit low product is accumulated from partial products. Depends on ckd_pkg.
module ckd_murmur
	import ckd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  ckd_ctl_t     ctl,
	input  logic [63:0]  lo,
	input  logic [63:0]  hi,
	input  logic [31:0]  seed,
	output logic         done,
	output logic [127:0] hash
);
	mm_step_t    step_q;
	logic        busy_q;
	logic [1:0]  mph_q;
	logic [63:0] h1_q, h2_q, k_q, lo_q, hi_q, acc_q;
	logic [63:0] ma, mb, prod, pp;
	logic [31:0] mx, my;
	logic        needs_mul;
	logic [63:0] x1, r1, x2, r2, f1, fm;

	// multiplier operand select
	always_comb begin
		ma = k_q;
		mb = MM_C1;
		case (step_q)
			MM_K1A: begin ma = lo_q; mb = MM_C1; end
			MM_K1B: begin ma = {k_q[32:0], k_q[63:33]}; mb = MM_C2; end
			MM_K2A: begin ma = hi_q; mb = MM_C2; end
			MM_K2B: begin ma = {k_q[30:0], k_q[63:31]}; mb = MM_C1; end
			MM_F1A, MM_F2A: begin ma = k_q ^ (k_q >> 33); mb = FMIX_M1; end
			MM_F1B, MM_F2B: begin ma = k_q ^ (k_q >> 33); mb = FMIX_M2; end
			default: begin ma = k_q; mb = MM_C1; end
		endcase
	end

	// partial products: lo*lo, lo*hi, hi*lo
	always_comb begin
		case (mph_q)
			2'd0: begin mx = ma[31:0]; my = mb[31:0]; end
			2'd1: begin mx = ma[31:0]; my = mb[63:32]; end
			default: begin mx = ma[63:32]; my = mb[31:0]; end
		endcase
	end
	assign pp = {32'd0, mx} * {32'd0, my};
	assign prod = acc_q;
	assign needs_mul = (step_q != MM_FIN) && (step_q != MM_DONE);

	assign x1 = h1_q ^ prod;
	assign r1 = {x1[36:0], x1[63:37]} + h2_q;
	assign x2 = h2_q ^ prod;
	assign r2 = {x2[32:0], x2[63:33]} + h1_q;
	assign f1 = (h1_q ^ DESC_LEN) + (h2_q ^ DESC_LEN);
	assign fm = prod ^ (prod >> 33);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= MM_K1A;
			mph_q <= 2'd0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			step_q <= MM_K1A;
			mph_q <= 2'd0;
			h1_q <= {32'd0, seed};
			h2_q <= {32'd0, seed};
			lo_q <= lo;
			hi_q <= hi;
		end else if (busy_q) begin
			if (needs_mul && mph_q != 2'd3) begin
				mph_q <= mph_q + 2'd1;
				if (mph_q == 2'd0)
					acc_q <= pp;
				else
					acc_q[63:32] <= acc_q[63:32] + pp[31:0];
			end else begin
				mph_q <= 2'd0;
				case (step_q)
					MM_K1A: begin k_q <= prod; step_q <= MM_K1B; end
					MM_K1B: begin
						h1_q <= (r1 << 2) + r1 + 64'h52dce729;
						step_q <= MM_K2A;
					end
					MM_K2A: begin k_q <= prod; step_q <= MM_K2B; end
					MM_K2B: begin
						h2_q <= (r2 << 2) + r2 + 64'h38495ab5;
						step_q <= MM_FIN;
					end
					MM_FIN: begin
						h1_q <= f1;
						h2_q <= (h2_q ^ DESC_LEN) + f1;
						k_q <= f1;
						step_q <= MM_F1A;
					end
					MM_F1A: begin k_q <= prod; step_q <= MM_F1B; end
					MM_F1B: begin
						h1_q <= fm;
						k_q <= h2_q;
						step_q <= MM_F2A;
					end
					MM_F2A: begin k_q <= prod; step_q <= MM_F2B; end
					MM_F2B: begin
						h1_q <= h1_q + fm;
						h2_q <= h1_q + fm + fm;
						step_q <= MM_DONE;
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	assign done = busy_q && (step_q == MM_DONE);
	assign hash = {h2_q, h1_q};
endmodule

>>> rtl/ckd_md5.sv
// ckd_md5: single-block MD5 of a 16-byte message, one round per cycle.
// Depends on ckd_pkg.
module ckd_md5
	import ckd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  ckd_ctl_t     ctl,
	input  logic [127:0] msg,
	output logic         done,
	output logic [127:0] digest
);
	logic        busy_q, fin_q;
	logic [5:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [127:0] msg_q;
	logic [31:0] f, mg, sum, rsum;
	logic [3:0]  g;
	logic [4:0]  s;

	always_comb begin
		case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		g = md5_g(rnd_q);
		s = md5_s(rnd_q);
		case (g)
			4'd0: mg = msg_q[31:0];
			4'd1: mg = msg_q[63:32];
			4'd2: mg = msg_q[95:64];
			4'd3: mg = msg_q[127:96];
			4'd4: mg = 32'h80;
			4'd14: mg = 32'd128;
			default: mg = 32'd0;
		endcase
		sum = f + a_q + md5_k(rnd_q) + mg;
		rsum = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			rnd_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			fin_q <= 1'b0;
			rnd_q <= '0;
			msg_q <= msg;
			a_q <= MD5_A0; b_q <= MD5_B0; c_q <= MD5_C0; d_q <= MD5_D0;
		end else if (busy_q) begin
			a_q <= d_q; d_q <= c_q; c_q <= b_q;
			b_q <= b_q + rsum;
			rnd_q <= rnd_q + 6'd1;
			if (rnd_q == 6'd63) begin
				busy_q <= 1'b0;
				fin_q <= 1'b1;
			end
		end else begin
			fin_q <= 1'b0;
		end
	end

	assign done = fin_q;
	assign digest = {d_q + MD5_D0, c_q + MD5_C0, b_q + MD5_B0, a_q + MD5_A0};
endmodule

>>> rtl/chunk_keystream_decrypt.sv
// chunk_keystream_decrypt: per-chunk XOR keystream decryptor.
// Depends on ckd_pkg, ckd_stream_if, ckd_murmur, ckd_md5.
//
// Requests arrive on in_ch (valid/ready). func=0 carries a 16-byte chunk
// descriptor; the block hashes it with MurmurHash3 x64 128 (each 64-bit
// product uses one shared 32x32 multiplier), XORs in the key words, and
// runs MD5 one round per cycle (64 rounds plus handoff). A start request
// thus holds ready low until the new digest is stored and gives no result.
// func=1 requests carry up to 8 bytes that are XORed with the held digest at
// the running chunk byte phase; each passes through one result register and
// gives one result on out_ch in the cycle after accept.
// A result waits in its register while out_ch.ready is low; no new request
// is taken until it leaves. Counts above 8 saturate to 8; unused bytes are 0.
// The APB port writes hash_seed and key_word0..3 at 4*i; reads return them.
// The user must make writes only while the block is idle; the block does not enforce it.
// Reset (arst_n low) clears registers, digest and phase to zero.
module chunk_keystream_decrypt
	import ckd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ckd_stream_if.sink   in_ch,
	ckd_stream_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	ckd_state_t   state_q, state_nx;
	logic [31:0]  seed_q, key0_q, key1_q, key2_q, key3_q;
	logic [127:0] digest_q, hash;
	logic [3:0]   phase_q;
	logic         mm_done, md_done;
	logic [127:0] md_digest;
	ckd_ctl_t     mm_ctl, md_ctl;
	logic         in_acc, out_acc;
	logic [63:0]  plain_q;
	logic [3:0]   cnt_q;
	logic         last_q;
	logic [3:0]   cnt;
	logic [63:0]  plain;
	reg_idx_t     widx;

	assign pready = 1'b1;
	assign widx = reg_idx_t'(paddr[4:2]);
	always_comb begin
		case (widx)
			REG_SEED: prdata = seed_q;
			REG_KEY0: prdata = key0_q;
			REG_KEY1: prdata = key1_q;
			REG_KEY2: prdata = key2_q;
			REG_KEY3: prdata = key3_q;
			default: prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0; key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (widx)
				REG_SEED: seed_q <= pwdata;
				REG_KEY0: key0_q <= pwdata;
				REG_KEY1: key1_q <= pwdata;
				REG_KEY2: key2_q <= pwdata;
				REG_KEY3: key3_q <= pwdata;
				default: ;
			endcase
		end
	end

	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_acc) state_nx = (in_ch.func == FUNC_START) ? ST_HASH : ST_OUT;
			ST_HASH: if (mm_done) state_nx = ST_MD5;
			ST_MD5:  if (md_done) state_nx = ST_IDLE;
			ST_OUT:  if (out_acc) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		out_ch.valid = (state_q == ST_OUT);
		mm_ctl.start = in_acc && (in_ch.func == FUNC_START);
		mm_ctl.done = 1'b0;
		md_ctl.start = (state_q == ST_HASH) && mm_done;
		md_ctl.done = 1'b0;
	end

	ckd_murmur u_mm (
		.clk, .arst_n, .ctl(mm_ctl), .lo(in_ch.desc_low), .hi(in_ch.desc_high),
		.seed(seed_q), .done(mm_done), .hash
	);

	ckd_md5 u_md5 (
		.clk, .arst_n, .ctl(md_ctl),
		.msg(hash ^ {key3_q, key2_q, key1_q, key0_q}),
		.done(md_done), .digest(md_digest)
	);

	assign cnt = in_ch.byte_count[3] ? 4'd8 : in_ch.byte_count;
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			logic [3:0] p;
			p = phase_q + 4'(k);
			plain[8*k +: 8] = (4'(k) < cnt) ?
				(in_ch.data_word[8*k +: 8] ^ digest_q[8*p +: 8]) : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			digest_q <= '0;
			phase_q <= '0;
		end else begin
			state_q <= state_nx;
			if (md_done && state_q == ST_MD5) begin
				digest_q <= md_digest;
			end
			if (mm_ctl.start) begin
				phase_q <= '0;
			end else if (in_acc) begin
				phase_q <= in_ch.last_in ? 4'd0 : phase_q + cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			plain_q <= plain;
			cnt_q <= cnt;
			last_q <= in_ch.last_in;
		end
	end

	always_comb begin
		out_ch.plain_word = plain_q;
		out_ch.plain_count = cnt_q;
		out_ch.last_out = last_q;
		out_ch.func = FUNC_DATA;
		out_ch.desc_low = '0;
		out_ch.desc_high = '0;
		out_ch.data_word = '0;
		out_ch.byte_count = '0;
		out_ch.last_in = 1'b0;
	end

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HASH || state_q == ST_MD5) |-> !in_ch.ready)
		else $error("ready during key derivation");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(plain_q)))
		else $error("result dropped while stalled");
	a_last_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.func == FUNC_DATA && in_ch.last_in) |=> (phase_q == 4'd0))
		else $error("phase not cleared at chunk end");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.plain_count <= 4'd8))
		else $error("count above eight");
endmodule

>>> sim/testbench.sv
// testbench: self-checking bench for chunk_keystream_decrypt.
// Holds its own Murmur/MD5 keystream predictor; drives valid/ready and APB.
// Depends on ckd_pkg, ckd_stream_if and chunk_keystream_decrypt from the RTL.
`timescale 1ns / 1ps

module testbench;
	import ckd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 150;

	typedef struct {
		logic        func;
		logic [63:0] desc_low;
		logic [63:0] desc_high;
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        last_in;
	} chunk_req_t;

	typedef struct {
		logic [63:0] plain_word;
		logic [3:0]  plain_count;
		logic        last_out;
	} plain_res_t;

	class keystream_board;
		logic [31:0] seed;
		logic [31:0] key [4];
		logic [7:0]  digest [16];
		logic [3:0]  phase;
		plain_res_t  pending_q [$];
		int          errors;

		function new();
			seed = '0;
			foreach (key[i]) key[i] = '0;
			foreach (digest[i]) digest[i] = '0;
			phase = '0;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] v);
			if (idx == REG_SEED) seed = v;
			else key[int'(idx) - 1] = v;
		endfunction

		function logic [63:0] rol64(logic [63:0] x, int r);
			return (x << r) | (x >> (64 - r));
		endfunction

		function logic [31:0] rol32(logic [31:0] x, int r);
			return (x << r) | (x >> (32 - r));
		endfunction

		function logic [63:0] fmix(logic [63:0] k);
			k = k ^ (k >> 33);
			k = k * 64'hff51afd7ed558ccd;
			k = k ^ (k >> 33);
			k = k * 64'hc4ceb9fe1a85ec53;
			k = k ^ (k >> 33);
			return k;
		endfunction

		function void derive_key(logic [63:0] lo, logic [63:0] hi);
			logic [63:0] h1, h2, k1, k2;
			logic [31:0] w [4];
			logic [31:0] m [16];
			logic [31:0] a, b, c, d, f, st [4];
			int g, s;
			int rot [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
			h1 = {32'h0, seed};
			h2 = h1;
			k1 = lo * 64'h87c37b91114253d5;
			k1 = rol64(k1, 31) * 64'h4cf5ad432745937f;
			h1 = h1 ^ k1;
			h1 = rol64(h1, 27) + h2;
			h1 = h1 * 5 + 64'h52dce729;
			k2 = hi * 64'h4cf5ad432745937f;
			k2 = rol64(k2, 33) * 64'h87c37b91114253d5;
			h2 = h2 ^ k2;
			h2 = rol64(h2, 31) + h1;
			h2 = h2 * 5 + 64'h38495ab5;
			h1 = h1 ^ 64'h10;
			h2 = h2 ^ 64'h10;
			h1 = h1 + h2; h2 = h2 + h1;
			h1 = fmix(h1); h2 = fmix(h2);
			h1 = h1 + h2; h2 = h2 + h1;
			w[0] = h1[31:0]; w[1] = h1[63:32]; w[2] = h2[31:0]; w[3] = h2[63:32];
			foreach (m[i]) m[i] = '0;
			for (int i = 0; i < 4; i++) m[i] = w[i] ^ key[i];
			m[4] = 32'h80;
			m[14] = 32'd128;
			a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
			for (int i = 0; i < 64; i++) begin
				if (i < 16) begin
					f = (b & c) | (~b & d); g = i;
				end else if (i < 32) begin
					f = (b & d) | (c & ~d); g = (5 * i + 1) & 15;
				end else if (i < 48) begin
					f = b ^ c ^ d; g = (3 * i + 5) & 15;
				end else begin
					f = c ^ (b | ~d); g = (7 * i) & 15;
				end
				f = f + a + md5_k(6'(i)) + m[g];
				s = rot[((i >> 4) << 2) | (i & 3)];
				a = d; d = c; c = b;
				b = b + rol32(f, s);
			end
			st[0] = a + 32'h67452301; st[1] = b + 32'hefcdab89;
			st[2] = c + 32'h98badcfe; st[3] = d + 32'h10325476;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					digest[i * 4 + j] = st[i][8 * j +: 8];
		endfunction

		function void note_request(chunk_req_t r);
			plain_res_t e;
			int n;
			if (r.func == FUNC_START) begin
				derive_key(r.desc_low, r.desc_high);
				phase = '0;
				return;
			end
			n = (r.byte_count > 8) ? 8 : r.byte_count;
			e.plain_word = '0;
			for (int k = 0; k < n; k++)
				e.plain_word[8 * k +: 8] = r.data_word[8 * k +: 8] ^ digest[4'(phase + k)];
			e.plain_count = 4'(n);
			e.last_out = r.last_in;
			phase = r.last_in ? 4'd0 : 4'(phase + n);
			pending_q = {pending_q, e};
		endfunction

		function void check_result(plain_res_t a);
			plain_res_t e;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word=%h count=%0d last=%0b",
						a.plain_word, a.plain_count, a.last_out);
				return;
			end
			e = pending_q.pop_front();
			if (a.plain_word !== e.plain_word || a.plain_count !== e.plain_count ||
				a.last_out !== e.last_out) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp word=%h count=%0d last=%0b, got word=%h count=%0d last=%0b",
						e.plain_word, e.plain_count, e.last_out,
						a.plain_word, a.plain_count, a.last_out);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	ckd_stream_if in_ch();
	ckd_stream_if out_ch();

	keystream_board board = new();
	int tx_idle_pct = 7;
	int rx_idle_pct = 65;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_cnt = 0;
	int cycles = 0;

	chunk_keystream_decrypt DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_DATA;
		in_ch.desc_low = '0;
		in_ch.desc_high = '0;
		in_ch.data_word = '0;
		in_ch.byte_count = '0;
		in_ch.last_in = 1'b0;
		in_ch.plain_word = '0;
		in_ch.plain_count = '0;
		in_ch.last_out = 1'b0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random stalls plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_cnt <= 400;
			out_ch.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		chunk_req_t r;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			r.func = in_ch.func;
			r.desc_low = in_ch.desc_low;
			r.desc_high = in_ch.desc_high;
			r.data_word = in_ch.data_word;
			r.byte_count = in_ch.byte_count;
			r.last_in = in_ch.last_in;
			board.note_request(r);
		end
	end

	always @(posedge clk) begin
		plain_res_t a;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			a.plain_word = out_ch.plain_word;
			a.plain_count = out_ch.plain_count;
			a.last_out = out_ch.last_out;
			board.check_result(a);
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send(chunk_req_t r);
		in_ch.valid <= 1'b1;
		in_ch.func <= r.func;
		in_ch.desc_low <= r.desc_low;
		in_ch.desc_high <= r.desc_high;
		in_ch.data_word <= r.data_word;
		in_ch.byte_count <= r.byte_count;
		in_ch.last_in <= r.last_in;
		do @(posedge clk); while (!in_ch.ready);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_start(logic [63:0] lo, logic [63:0] hi);
		chunk_req_t r;
		r.func = FUNC_START; r.desc_low = lo; r.desc_high = hi;
		r.data_word = rand64(); r.byte_count = 4'($urandom); r.last_in = 1'($urandom);
		send(r);
	endtask

	task automatic send_data(logic [63:0] w, logic [3:0] n, logic last);
		chunk_req_t r;
		r.func = FUNC_DATA; r.desc_low = rand64(); r.desc_high = rand64();
		r.data_word = w; r.byte_count = n; r.last_in = last;
		send(r);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(int'(idx) * 4); pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		board.set_reg(idx, v);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic configure(logic [31:0] s, logic [31:0] k0, logic [31:0] k1,
		logic [31:0] k2, logic [31:0] k3);
		drain();
		apb_write(REG_SEED, s);
		apb_write(REG_KEY0, k0);
		apb_write(REG_KEY1, k1);
		apb_write(REG_KEY2, k2);
		apb_write(REG_KEY3, k3);
		@(posedge clk);
	endtask

	function automatic logic [3:0] pick_count();
		int p;
		p = $urandom_range(99);
		if (p < 4) return 4'd0;
		if (p < 10) return 4'($urandom_range(9, 15));
		return 4'($urandom_range(1, 8));
	endfunction

	task automatic random_chunks(int n_req);
		int sent, len;
		chunk_req_t r;
		sent = 0;
		while (sent < n_req) begin
			if ($urandom_range(99) < 3)
				drain();
			if ($urandom_range(99) < 8) begin
				r.func = 1'($urandom); r.desc_low = rand64(); r.desc_high = rand64();
				r.data_word = rand64(); r.byte_count = 4'($urandom);
				r.last_in = 1'($urandom);
				send(r);
				sent++;
			end else begin
				send_start(rand64(), rand64());
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++)
					send_data(rand64(), pick_count(), i == len - 1);
				sent += len + 1;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// data before any chunk start uses the zero digest
		send_data(64'hffffffffffffffff, 4'd8, 1'b0);
		send_data(64'h0123456789abcdef, 4'd15, 1'b0);
		send_data(64'hffffffffffffffff, 4'd0, 1'b1);
		send_start(64'h0, 64'h0);
		send_data(64'hffffffffffffffff, 4'd3, 1'b0);
		send_data(64'hffffffffffffffff, 4'd8, 1'b0);
		send_data(64'h0, 4'd0, 1'b0);
		send_data(64'h5555555555555555, 4'd7, 1'b0);
		send_data(64'haaaaaaaaaaaaaaaa, 4'd1, 1'b1);
		send_data(64'h0, 4'd8, 1'b0);
		send_start(64'hffffffffffffffff, 64'hffffffffffffffff);
		send_data(64'h0, 4'd9, 1'b0);
		send_data(64'h0, 4'd8, 1'b0);
		send_data(64'h0, 4'd8, 1'b1);
		send_start(64'h8000000000000001, 64'h0123456789abcdef);
		send_data(64'hffffffffffffffff, 4'd1, 1'b1);

		configure('1, '1, '1, '1, '1);
		send_start(64'h0, 64'hffffffffffffffff);
		send_data(64'h0, 4'd8, 1'b0);
		send_data(64'hffffffffffffffff, 4'd8, 1'b1);
		random_chunks(180);

		configure($urandom, $urandom, $urandom, $urandom, $urandom);
		tx_idle_pct = 65; rx_idle_pct = 7;
		random_chunks(200);

		configure($urandom, $urandom, $urandom, $urandom, $urandom);
		tx_idle_pct = 0; rx_idle_pct = 0;
		random_chunks(100);
		hold_seq <= hold_seq + 1;
		for (int i = 0; i < 40; i++)
			send_data(rand64(), 4'($urandom_range(1, 8)), i == 39);
		random_chunks(100);

		configure('0, '0, '0, '0, '0);
		random_chunks(180);
		drain();

		if (board.errors == 0 && board.pending_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
